@@ design/ndcd_pkg.sv @@
// shared types, constants and helpers for the neighbour difference corner detector
`timescale 1ns / 1ps

package ndcd_pkg;

	// default line length the line memory is sized for
	localparam int NDCD_MAX_COLS = 1024;

	// field and register widths
	localparam int PIX_W      = 8;
	localparam int THR_W      = 11;
	localparam int FW_W       = 11;
	localparam int FH_W       = 16;
	localparam int SUM_W      = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// command codes
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

	// register reset values
	localparam logic [THR_W-1:0] THR_RESET    = 11'd1024;
	localparam logic [FW_W-1:0]  WIDTH_RESET  = 11'd640;
	localparam logic [FH_W-1:0]  HEIGHT_RESET = 16'd480;

	// result codes
	localparam logic [PIX_W-1:0] CORNER_ON  = 8'hFF;
	localparam logic [PIX_W-1:0] CORNER_OFF = 8'h00;

	// input word
	typedef struct packed {
		logic             cmd;
		logic [PIX_W-1:0] pixel_value;
	} ndcd_in_t;

	// result word
	typedef struct packed {
		logic [PIX_W-1:0] corner_value;
		logic             last_of_frame;
	} ndcd_out_t;

	// absolute difference of two pixels
	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		absdiff = (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

@@ design/ndcd_ram.sv @@
// generic simple dual port ram with registered read
`timescale 1ns / 1ps

module ndcd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ design/neighbour_difference_corner_detect.sv @@
// top level of the 3x3 neighbour difference corner detector
`timescale 1ns / 1ps

// Streams 8-bit pixels of one band in raster order, one pixel word per clock while
// pix_stall is low, and returns one result word per pixel of the frame: 255 where
// the sum of absolute differences between a pixel and its eight neighbours exceeds
// the threshold register, 0 elsewhere and on every border pixel. Results lag the
// input by one row plus one pixel; flush words (cmd = 1) drain the remaining
// results once every pixel of the frame has arrived, and the final result carries
// last_of_frame. The sustained rate is one word per clock unless the output stalls:
// the two line buffers share one memory read at word acceptance, and a single stage
// (window shift, eight differences, adder tree and threshold compare) sits between
// the input register and the result register. The line memory needs no clearing
// after reset. Configuration must be written with the block idle; the block itself
// does not enforce this. A width or height write restarts the frame.
module neighbour_difference_corner_detect #(
	parameter int MAX_COLS = ndcd_pkg::NDCD_MAX_COLS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             pix_valid,
	output logic                             pix_stall,
	input  ndcd_pkg::ndcd_in_t               pix_data,
	output logic                             res_valid,
	input  logic                             res_stall,
	output ndcd_pkg::ndcd_out_t              res_data,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ndcd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ndcd_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import ndcd_pkg::*;

	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int LINE_W = 2 * PIX_W;

	typedef struct packed {
		logic pixel;
		logic centre_ok;
		logic emit;
		logic last;
	} ctl_t;

	// configuration registers
	logic [THR_W-1:0] thr_q;
	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic             cfg_we;
	logic             cfg_restart;

	// frame geometry
	logic [COL_W-1:0] w_last;
	logic [FH_W-1:0]  h_last;

	// position counters
	logic [COL_W-1:0] in_col_q;
	logic [FH_W-1:0]  in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [FH_W-1:0]  out_row_q;

	// front decode
	logic pix_acc;
	logic complete;
	logic is_pix;
	ctl_t ctl_f;

	// stage one
	logic             s1_valid_q;
	ctl_t             ctl_s1;
	logic [PIX_W-1:0] pixel_s1;
	logic [COL_W-1:0] col_s1;
	logic             fwd_s1;
	logic [LINE_W-1:0] fwd_line_s1;
	logic             s1_adv;

	// line memory
	logic              line_we;
	logic [LINE_W-1:0] line_wdata;
	logic [LINE_W-1:0] line_rd;
	logic [LINE_W-1:0] line_eff;

	// window and score
	logic [2:0][2:0][PIX_W-1:0] win_q;
	logic [2:0][2:0][PIX_W-1:0] win_nx;
	logic [PIX_W-1:0]           centre;
	logic [SUM_W-1:0]           sum;
	logic                       corner;

	// result register
	logic      res_valid_q;
	ndcd_out_t res_q;

	// configuration writes
	assign cfg_ready   = 1'b1;
	assign cfg_we      = cfg_valid && cfg_ready;
	assign cfg_restart = cfg_we && (cfg_index == CFG_WIDTH || cfg_index == CFG_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
			fw_q  <= WIDTH_RESET;
			fh_q  <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				CFG_WIDTH:     fw_q  <= cfg_data[FW_W-1:0];
				CFG_HEIGHT:    fh_q  <= cfg_data[FH_W-1:0];
				default: ;
			endcase
		end
	end

	// last column and row, width clamped to the line memory
	always_comb begin
		if (fw_q == '0) begin
			w_last = '0;
		end else if (int'(fw_q) > MAX_COLS) begin
			w_last = COL_W'(MAX_COLS - 1);
		end else begin
			w_last = COL_W'(fw_q - 1'b1);
		end
		h_last = (fh_q == '0) ? '0 : (fh_q - 1'b1);
	end

	// classify the incoming word
	assign pix_acc  = pix_valid && !pix_stall;
	assign complete = in_row_q > h_last;
	assign is_pix   = (pix_data.cmd == CMD_PIXEL) && !complete;

	always_comb begin
		ctl_f.pixel     = is_pix;
		ctl_f.centre_ok = is_pix && (in_row_q >= FH_W'(2)) && (in_col_q >= COL_W'(2));
		ctl_f.emit      = complete || (is_pix && ((in_row_q >= FH_W'(2))
			|| (in_row_q == FH_W'(1) && in_col_q != '0)));
		ctl_f.last      = (out_col_q == w_last) && (out_row_q == h_last);
	end

	// input and output positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (cfg_restart || (pix_acc && ctl_f.emit && ctl_f.last)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
		end else if (pix_acc) begin
			if (is_pix) begin
				if (in_col_q == w_last) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + 1'b1;
				end else begin
					in_col_q <= in_col_q + 1'b1;
				end
			end
			if (ctl_f.emit) begin
				if (out_col_q == w_last) begin
					out_col_q <= '0;
					out_row_q <= out_row_q + 1'b1;
				end else begin
					out_col_q <= out_col_q + 1'b1;
				end
			end
		end
	end

	// stage one advances unless its result finds the output full
	assign s1_adv    = s1_valid_q && (!ctl_s1.emit || !res_valid_q || !res_stall);
	assign pix_stall = s1_valid_q && !s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (pix_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage one payload, with bypass when the same column is rewritten
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			ctl_s1      <= ctl_f;
			pixel_s1    <= pix_data.pixel_value;
			col_s1      <= in_col_q;
			fwd_s1      <= line_we && (col_s1 == in_col_q);
			fwd_line_s1 <= line_wdata;
		end
	end

	// line memory holds upper and middle rows side by side
	assign line_eff   = fwd_s1 ? fwd_line_s1 : line_rd;
	assign line_we    = s1_adv && ctl_s1.pixel;
	assign line_wdata = {line_eff[PIX_W-1:0], pixel_s1};

	ndcd_ram #(
		.WIDTH (LINE_W),
		.DEPTH (MAX_COLS)
	) u_line_ram (
		.clk   (clk),
		.we    (line_we),
		.waddr (col_s1),
		.wdata (line_wdata),
		.re    (pix_acc && is_pix),
		.raddr (in_col_q),
		.rdata (line_rd)
	);

	// shifted window
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win_nx[r][0] = win_q[r][1];
			win_nx[r][1] = win_q[r][2];
		end
		win_nx[0][2] = line_eff[LINE_W-1:PIX_W];
		win_nx[1][2] = line_eff[PIX_W-1:0];
		win_nx[2][2] = pixel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (s1_adv && ctl_s1.pixel) begin
			win_q <= win_nx;
		end
	end

	// sum of differences to the centre and threshold compare
	always_comb begin
		centre = win_nx[1][1];
		sum    = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				sum = sum + SUM_W'(absdiff(centre, win_nx[r][c]));
			end
		end
		corner = ctl_s1.centre_ok && (sum > thr_q);
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (s1_adv && ctl_s1.emit) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl_s1.emit) begin
			res_q.corner_value  <= corner ? CORNER_ON : CORNER_OFF;
			res_q.last_of_frame <= ctl_s1.last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// frame end returns every position counter to the start
	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		pix_acc && ctl_f.emit && ctl_f.last |=>
			(in_col_q == '0 && in_row_q == '0 && out_col_q == '0 && out_row_q == '0))
		else $error("position counters not cleared after frame end");

	// input column stays inside the row
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_col_q <= w_last)
		else $error("input column beyond row end");

	// output column stays inside the row
	a_out_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_col_q <= w_last)
		else $error("output column beyond row end");

	// results are only full scale or zero
	a_corner_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.corner_value == CORNER_ON || res_q.corner_value == CORNER_OFF))
		else $error("corner value neither on nor off");

endmodule

@@ test/neighbour_difference_corner_detect_test.sv @@
// self-checking testbench for the neighbour difference corner detector
`timescale 1ns / 1ps

module neighbour_difference_corner_detect_test;
	import ndcd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int IDLE_GUARD  = 8;
	localparam int REPORT_CAP  = 50;
	localparam int OUT_POS_MASK = 26'h3FFFFFF;
	// index past the last register, written to check it is ignored
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	// pixel textures for generated frames
	typedef enum int {TEX_NOISE, TEX_BINARY, TEX_SMOOTH, TEX_SPECKLE} texture_e;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  pix_valid = 1'b0;
	logic                  pix_stall;
	ndcd_in_t              pix_data  = '0;
	logic                  res_valid;
	logic                  res_stall = 1'b0;
	ndcd_out_t             res_data;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	// expected result words, oldest first
	ndcd_out_t corner_q[$];

	// mirror of the block's registers and frame state
	logic [THR_W-1:0] thr_reg;
	logic [FW_W-1:0]  width_reg;
	logic [FH_W-1:0]  height_reg;
	logic [PIX_W-1:0] line_upper [NDCD_MAX_COLS];
	logic [PIX_W-1:0] line_middle [NDCD_MAX_COLS];
	logic [PIX_W-1:0] win_px [3][3];
	int unsigned      col_in;
	int unsigned      row_in;
	int unsigned      out_count;

	// run statistics
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_request  = 0;
	int hold_left     = 0;
	int cycle_count   = 0;
	int words_sent    = 0;
	int results_seen  = 0;
	int frames_seen   = 0;
	int corners_seen  = 0;
	int cfg_writes    = 0;
	int fail_count    = 0;

	neighbour_difference_corner_detect dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// run length guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycle_count,
				corner_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// effective frame size after clamping
	function automatic int unsigned cols_used();
		if (width_reg == 0)
			return 1;
		if (width_reg > NDCD_MAX_COLS)
			return NDCD_MAX_COLS;
		return width_reg;
	endfunction

	function automatic int unsigned rows_used();
		return (height_reg == 0) ? 1 : height_reg;
	endfunction

	function automatic void restart_frame();
		col_in = 0;
		row_in = 0;
		out_count = 0;
	endfunction

	function automatic void reset_mirror();
		thr_reg = THR_RESET;
		width_reg = WIDTH_RESET;
		height_reg = HEIGHT_RESET;
		foreach (line_upper[i]) begin
			line_upper[i] = '0;
			line_middle[i] = '0;
		end
		foreach (win_px[r, c])
			win_px[r][c] = '0;
		restart_frame();
	endfunction

	function automatic void apply_config(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
			CFG_THRESHOLD: thr_reg = data[THR_W-1:0];
			CFG_WIDTH: begin
				width_reg = data[FW_W-1:0];
				restart_frame();
			end
			CFG_HEIGHT: begin
				height_reg = data[FH_W-1:0];
				restart_frame();
			end
			default: ;
		endcase
	endfunction

	// works out the result word, if any, that one accepted input word causes
	function automatic void predict_corner(input ndcd_in_t w);
		int unsigned wd, ht, col, n, sum;
		int c, p;
		logic [PIX_W-1:0] value;
		bit produce;
		ndcd_out_t res;
		wd = cols_used();
		ht = rows_used();
		value = CORNER_OFF;
		if (w.cmd == CMD_FLUSH || row_in >= ht) begin
			// only a finished frame drains, and only up to its pixel count
			produce = (row_in >= ht) && (out_count < wd * ht);
		end else begin
			col = col_in % NDCD_MAX_COLS;
			for (int r = 0; r < 3; r++) begin
				win_px[r][0] = win_px[r][1];
				win_px[r][1] = win_px[r][2];
			end
			win_px[0][2] = line_upper[col];
			win_px[1][2] = line_middle[col];
			win_px[2][2] = w.pixel_value;
			line_upper[col] = line_middle[col];
			line_middle[col] = w.pixel_value;
			// centre sits one row up and one column left of the new pixel
			if (row_in >= 2 && col_in >= 2) begin
				c = win_px[1][1];
				sum = 0;
				for (int i = 0; i < 3; i++)
					for (int j = 0; j < 3; j++) begin
						p = win_px[i][j];
						sum += (c > p) ? c - p : p - c;
					end
				if (sum > thr_reg)
					value = CORNER_ON;
			end
			n = row_in * wd + col_in;
			col_in++;
			if (col_in >= wd) begin
				col_in = 0;
				row_in++;
			end
			produce = (n >= wd + 1);
		end
		if (produce) begin
			res.corner_value = value;
			res.last_of_frame = (out_count + 1 >= wd * ht);
			out_count = (out_count + 1) & OUT_POS_MASK;
			if (res.last_of_frame)
				restart_frame();
			corner_q.push_back(res);
		end
	endfunction

	task automatic report_mismatch(input string field, input int want, input int got);
		fail_count++;
		if (fail_count <= REPORT_CAP)
			$error("%s expected %0d got %0d", field, want, got);
	endtask

	// result checker
	always @(posedge clk) begin
		ndcd_out_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (corner_q.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_CAP)
					$error("result word %h arrived with none expected", res_data);
			end else begin
				want = corner_q.pop_front();
				results_seen++;
				if (res_data.corner_value !== want.corner_value)
					report_mismatch("corner_value", want.corner_value,
						res_data.corner_value);
				if (res_data.last_of_frame !== want.last_of_frame)
					report_mismatch("last_of_frame", want.last_of_frame,
						res_data.last_of_frame);
				if (res_data.last_of_frame === 1'b1)
					frames_seen++;
				if (res_data.corner_value === CORNER_ON)
					corners_seen++;
			end
		end
	end

	// receiver stalls: random, or a long hold when asked for
	always @(posedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	// offers one word, with random idle cycles ahead of it, until taken
	task automatic send_word(input logic cmd, input logic [PIX_W-1:0] pix);
		ndcd_in_t w;
		w.cmd = cmd;
		w.pixel_value = pix;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix_valid <= 1'b1;
		pix_data <= w;
		@(posedge clk);
		while (pix_stall)
			@(posedge clk);
		words_sent++;
		predict_corner(w);
	endtask

	// stops sending and lets every pending result come back
	task automatic wait_idle();
		pix_valid <= 1'b0;
		while (corner_q.size() != 0)
			@(posedge clk);
		repeat (IDLE_GUARD)
			@(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		cfg_writes++;
		apply_config(idx, data);
		@(posedge clk);
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel(input texture_e tex, input int base);
		int v;
		case (tex)
			TEX_NOISE: v = $urandom_range(0, 255);
			TEX_BINARY: v = $urandom_range(0, 1) ? 255 : 0;
			TEX_SMOOTH: v = base + int'($urandom_range(0, 6)) - 3;
			default: v = ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 255)) : base;
		endcase
		if (v < 0)
			v = 0;
		if (v > 255)
			v = 255;
		return v[PIX_W-1:0];
	endfunction

	// sends pixels until the frame is complete or cut words have gone
	task automatic stream_frame(input texture_e tex, input int cut);
		int base, sent;
		base = $urandom_range(0, 255);
		sent = 0;
		while (row_in < rows_used() && (cut == 0 || sent < cut)) begin
			// stray flush inside the frame gives nothing
			if ($urandom_range(0, 99) < 4)
				send_word(CMD_FLUSH, 8'($urandom_range(0, 255)));
			send_word(CMD_PIXEL, pick_pixel(tex, base));
			sent++;
		end
	endtask

	// drains the held-back results; a pixel here counts as a flush
	task automatic drain_frame(input int pixel_pct);
		while (row_in >= rows_used()) begin
			if ($urandom_range(0, 99) < pixel_pct)
				send_word(CMD_PIXEL, 8'($urandom_range(0, 255)));
			else
				send_word(CMD_FLUSH, 8'($urandom_range(0, 255)));
		end
	endtask

	// one 3x3 frame: centre value, a ring value and a distinct top-left pixel
	task automatic tile3(input logic [PIX_W-1:0] centre, input logic [PIX_W-1:0] ring,
			input logic [PIX_W-1:0] top_left);
		for (int i = 0; i < 9; i++) begin
			if (i == 2)
				send_word(CMD_FLUSH, 8'hFF);
			send_word(CMD_PIXEL, (i == 4) ? centre : (i == 0) ? top_left : ring);
		end
		send_word(CMD_PIXEL, 8'h5A);
		drain_frame(0);
	endtask

	// first frame runs on the reset threshold
	task automatic test_first_frame();
		cfg_write(CFG_WIDTH, 16'd3);
		cfg_write(CFG_HEIGHT, 16'd3);
		send_word(CMD_FLUSH, 8'hA5);
		tile3(8'd0, 8'd255, 8'd255);
	endtask

	// compare level at and around the largest possible sum, and at zero
	task automatic test_threshold_edges();
		cfg_write(CFG_THRESHOLD, 16'd2040);
		tile3(8'd0, 8'd255, 8'd255);
		cfg_write(CFG_THRESHOLD, 16'hF7F7);
		tile3(8'd0, 8'd255, 8'd255);
		cfg_write(CFG_THRESHOLD, 16'hFFFF);
		tile3(8'd255, 8'd0, 8'd0);
		cfg_write(CFG_THRESHOLD, 16'd0);
		tile3(8'd10, 8'd10, 8'd10);
		tile3(8'd10, 8'd10, 8'd11);
	endtask

	// zero sizes, a single column, the unused index and a clamped row cut short
	task automatic test_size_limits();
		cfg_write(CFG_WIDTH, 16'd0);
		cfg_write(CFG_HEIGHT, 16'd0);
		send_word(CMD_PIXEL, 8'd77);
		drain_frame(0);
		cfg_write(CFG_WIDTH, 16'd1);
		cfg_write(CFG_HEIGHT, 16'd5);
		stream_frame(TEX_NOISE, 0);
		drain_frame(50);
		cfg_write(CFG_SPARE, 16'hFFFF);
		cfg_write(CFG_THRESHOLD, 16'd600);
		cfg_write(CFG_WIDTH, 16'hFFFF);
		cfg_write(CFG_HEIGHT, 16'd2);
		// results only start once the clamped row has wrapped
		stream_frame(TEX_SPECKLE, 1030);
	endtask

	// tallest frame left unfinished, then restarted by a height write
	task automatic test_frame_abandon();
		cfg_write(CFG_THRESHOLD, 16'd300);
		cfg_write(CFG_WIDTH, 16'd3);
		cfg_write(CFG_HEIGHT, 16'hFFFF);
		stream_frame(TEX_NOISE, 30);
		cfg_write(CFG_HEIGHT, 16'd4);
		stream_frame(TEX_NOISE, 0);
		drain_frame(20);
	endtask

	// long receiver hold fills the block; then the sender waits for every result
	task automatic test_backpressure();
		set_idling(0, 0);
		cfg_write(CFG_WIDTH, 16'd16);
		cfg_write(CFG_HEIGHT, 16'd6);
		hold_request = 400;
		stream_frame(TEX_SPECKLE, 40);
		pix_valid <= 1'b0;
		while (corner_q.size() != 0)
			@(posedge clk);
		stream_frame(TEX_SPECKLE, 0);
		drain_frame(0);
		stream_frame(TEX_BINARY, 0);
		drain_frame(0);
	endtask

	task automatic random_config();
		int pick;
		logic [FW_W-1:0] wd;
		logic [FH_W-1:0] ht;
		logic [CFG_DATA_W-1:0] data;
		pick = $urandom_range(0, 99);
		if (pick < 3) begin
			wd = FW_W'($urandom_range(41, 64));
			ht = FH_W'($urandom_range(1, 2));
		end else if (pick < 10) begin
			wd = FW_W'($urandom_range(0, 1));
			ht = FH_W'($urandom_range(0, 9));
		end else if (pick < 25) begin
			wd = FW_W'($urandom_range(13, 40));
			ht = FH_W'($urandom_range(0, 6));
		end else begin
			wd = FW_W'($urandom_range(2, 12));
			ht = FH_W'($urandom_range(0, 9));
		end
		data = CFG_DATA_W'($urandom_range(0, 65535));
		data[FW_W-1:0] = wd;
		cfg_write(CFG_WIDTH, data);
		cfg_write(CFG_HEIGHT, ht);
		if ($urandom_range(0, 99) < 60) begin
			data = CFG_DATA_W'($urandom_range(0, 65535));
			case ($urandom_range(0, 5))
				0: data[THR_W-1:0] = '0;
				1: data[THR_W-1:0] = THR_W'(2040);
				2: ;
				3: data[THR_W-1:0] = THR_W'(2039);
				default: data[THR_W-1:0] = THR_W'($urandom_range(8, 1200));
			endcase
			cfg_write(CFG_THRESHOLD, data);
		end
	endtask

	// mostly whole frames with random content, some cut short
	task automatic test_random_frames(input int send_pct, input int recv_pct,
			input int budget);
		int start, cut;
		bit abandon;
		set_idling(send_pct, recv_pct);
		start = words_sent;
		while (words_sent - start < budget) begin
			random_config();
			abandon = ($urandom_range(0, 9) == 0);
			cut = abandon ? int'($urandom_range(1, cols_used() * rows_used())) : 0;
			stream_frame(texture_e'($urandom_range(0, 3)), cut);
			if (!abandon)
				drain_frame(10);
		end
	endtask

	initial begin
		reset_mirror();
		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_first_frame();
		test_threshold_edges();
		test_size_limits();
		test_frame_abandon();
		test_backpressure();
		test_random_frames(26, 87, 150);
		test_random_frames(87, 26, 150);
		test_random_frames(0, 0, 160);
		wait_idle();
		repeat (20)
			@(posedge clk);
		$display("sent %0d words in %0d cycles, checked %0d results over %0d frames",
			words_sent, cycle_count, results_seen, frames_seen);
		$display("%0d corner results, %0d register writes, %0d mismatches",
			corners_seen, cfg_writes, fail_count);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
